// ===== rtl/lmn_pkg.sv =====
// ----------------------------------------------------------------------------
// lmn_pkg: shared types and constants for the Lamport mutex node
// Field widths, message codes, queue command/status structs and helpers.
// ----------------------------------------------------------------------------
package lmn_pkg;

  // Sizing
  localparam int MAX_NODES  = 16;
  localparam int CLOCK_BITS = 16;   // must be at least STAMP_W
  localparam int IDX_W      = $clog2(MAX_NODES);
  localparam int NODE_W     = 4;
  localparam int STAMP_W    = 16;
  localparam int FUNC_W     = 3;
  localparam int KIND_W     = 3;
  localparam int CNT_W      = 5;

  localparam logic [CNT_W-1:0]      CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CLOCK_BITS-1:0] CLOCK_MAX = {CLOCK_BITS{1'b1}};

  // Configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b1;
  localparam logic [CNT_W-1:0]     NODE_COUNT_RST = 5'd3;

  // Input function codes
  localparam logic [FUNC_W-1:0] FN_LOCAL_REQ    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_LOCAL_EXIT   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_GOT_REQ      = 3'd2;
  localparam logic [FUNC_W-1:0] FN_GOT_REPLY    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_GOT_RELEASE  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_GOT_DONE     = 3'd5;
  localparam logic [FUNC_W-1:0] FN_LOCAL_FINISH = 3'd6;
  localparam logic [FUNC_W-1:0] FN_UNUSED       = 3'd7;

  // Outgoing message kinds
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [NODE_W-1:0]  sender;
    logic [STAMP_W-1:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  send_kind;
    logic               send_broadcast;
    logic [NODE_W-1:0]  send_dest;
    logic [STAMP_W-1:0] send_stamp;
    logic               enter_granted;
    logic [STAMP_W-1:0] entry_clock;
  } out_item_t;

  typedef enum logic [1:0] {
    Q_NONE,
    Q_INSERT,
    Q_ERASE
  } q_op_t;

  // Command from the sequencer to the queue scan unit
  typedef struct packed {
    logic                  start;
    q_op_t                 op;
    logic [CLOCK_BITS-1:0] stamp;
    logic [NODE_W-1:0]     node;
  } q_cmd_t;

  // Status back from the queue scan unit
  typedef struct packed {
    logic                  done;
    logic                  head_valid;
    logic [CLOCK_BITS-1:0] head_stamp;
    logic [NODE_W-1:0]     head_node;
  } q_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // Queue order: by stamp, ties broken by node id
  function automatic logic key_less(input logic [CLOCK_BITS-1:0] sa,
                                    input logic [NODE_W-1:0]     na,
                                    input logic [CLOCK_BITS-1:0] sb,
                                    input logic [NODE_W-1:0]     nb);
    key_less = (sa < sb) || ((sa == sb) && (na < nb));
  endfunction

  // Saturating clock increment
  function automatic logic [CLOCK_BITS-1:0] clock_inc(input logic [CLOCK_BITS-1:0] v);
    clock_inc = (v == CLOCK_MAX) ? v : v + CLOCK_BITS'(1);
  endfunction

endpackage

// ===== rtl/lamport_mutex_node_top.sv =====
// ----------------------------------------------------------------------------
// lamport_mutex_node_top: one node of Lamport distributed mutual exclusion
// Keeps the Lamport clock, reply and finish counters, and drives the queue
// scan unit; produces one outgoing message / grant result per transaction.
// ----------------------------------------------------------------------------
// Each input transaction runs in steps from acceptance to its result: the
// clock and counters update at acceptance, then the queue scan unit visits
// one queue slot per cycle to match, insert or erase and find the head, the
// scan status is registered, and the grant decision is formed and loaded
// into the output register. in_ready is high only between transactions and
// returns the cycle after the result is loaded, so a new transaction is not
// accepted before the previous result is loaded; a result not yet taken
// stalls the next one in its last step. A finished result waits in the output
// register without holding off the next input.
module lamport_mutex_node_top (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [lmn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lmn_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input messages
  input  logic                               in_valid,
  output logic                               in_ready,
  input  lmn_pkg::in_item_t                  in_data,
  // results
  output logic                               out_valid,
  input  logic                               out_ready,
  output lmn_pkg::out_item_t                 out_data
);

  // Configuration
  logic [lmn_pkg::NODE_W-1:0] own_node;
  logic [lmn_pkg::CNT_W-1:0]  node_count;

  // Node state
  logic [lmn_pkg::CLOCK_BITS-1:0] logical_clock;
  logic [lmn_pkg::CNT_W-1:0]      reply_count;
  logic [lmn_pkg::CNT_W-1:0]      finished_peers;
  logic [lmn_pkg::CLOCK_BITS-1:0] own_stamp;
  logic                           waiting_entry;

  lmn_pkg::state_t state, state_next;

  // Message pending for the current transaction
  logic [lmn_pkg::KIND_W-1:0]  pend_kind;
  logic                        pend_bcast;
  logic [lmn_pkg::NODE_W-1:0]  pend_dest;
  logic [lmn_pkg::STAMP_W-1:0] pend_stamp;

  // Decode results
  logic                           accept;
  logic [lmn_pkg::CLOCK_BITS-1:0] stamp_ext;
  logic [lmn_pkg::CLOCK_BITS-1:0] clock_max;
  logic [lmn_pkg::CLOCK_BITS-1:0] logical_clock_next;
  logic [lmn_pkg::CNT_W-1:0]      reply_count_next;
  logic [lmn_pkg::CNT_W-1:0]      finished_peers_next;
  logic [lmn_pkg::CLOCK_BITS-1:0] own_stamp_next;
  logic                           waiting_entry_next;
  logic [lmn_pkg::KIND_W-1:0]     kind_next;
  logic                           bcast_next;
  logic [lmn_pkg::NODE_W-1:0]     dest_next;
  logic [lmn_pkg::STAMP_W-1:0]    sstamp_next;

  lmn_pkg::q_cmd_t  qcmd;
  lmn_pkg::q_stat_t qstat;

  // Grant decision
  logic [lmn_pkg::CNT_W-1:0] needed;
  logic                      grant;
  logic                      out_free;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == lmn_pkg::ST_IDLE);
  assign stamp_ext = lmn_pkg::CLOCK_BITS'(in_data.stamp);
  assign clock_max = (logical_clock > stamp_ext) ? logical_clock : stamp_ext;
  assign out_free  = !out_valid || out_ready;

  // Decode the incoming transaction
  always_comb begin
    logical_clock_next  = logical_clock;
    reply_count_next    = reply_count;
    finished_peers_next = finished_peers;
    own_stamp_next      = own_stamp;
    waiting_entry_next  = waiting_entry;
    kind_next           = lmn_pkg::KIND_NONE;
    bcast_next          = 1'b0;
    dest_next           = '0;
    sstamp_next         = '0;
    qcmd.start          = accept;
    qcmd.op             = lmn_pkg::Q_NONE;
    qcmd.stamp          = stamp_ext;
    qcmd.node           = in_data.sender;
    unique case (in_data.func)
      lmn_pkg::FN_LOCAL_REQ: begin
        if (!waiting_entry) begin
          logical_clock_next = lmn_pkg::clock_inc(logical_clock);
          own_stamp_next     = lmn_pkg::clock_inc(logical_clock);
          reply_count_next   = '0;
          waiting_entry_next = 1'b1;
          kind_next          = lmn_pkg::KIND_REQUEST;
          bcast_next         = 1'b1;
          sstamp_next        = lmn_pkg::STAMP_W'(own_stamp_next);
          qcmd.op            = lmn_pkg::Q_INSERT;
          qcmd.stamp         = own_stamp_next;
          qcmd.node          = own_node;
        end
      end
      lmn_pkg::FN_LOCAL_EXIT: begin
        waiting_entry_next = 1'b0;
        kind_next          = lmn_pkg::KIND_RELEASE;
        bcast_next         = 1'b1;
        sstamp_next        = lmn_pkg::STAMP_W'(own_stamp);
        qcmd.op            = lmn_pkg::Q_ERASE;
        qcmd.stamp         = own_stamp;
        qcmd.node          = own_node;
      end
      lmn_pkg::FN_GOT_REQ: begin
        logical_clock_next = lmn_pkg::clock_inc(clock_max);
        kind_next          = lmn_pkg::KIND_REPLY;
        dest_next          = in_data.sender;
        sstamp_next        = lmn_pkg::STAMP_W'(logical_clock_next);
        qcmd.op            = lmn_pkg::Q_INSERT;
      end
      lmn_pkg::FN_GOT_REPLY: begin
        if (reply_count != lmn_pkg::CNT_MAX) begin
          reply_count_next = reply_count + lmn_pkg::CNT_W'(1);
        end
      end
      lmn_pkg::FN_GOT_RELEASE: begin
        qcmd.op = lmn_pkg::Q_ERASE;
      end
      lmn_pkg::FN_GOT_DONE: begin
        if (finished_peers != lmn_pkg::CNT_MAX) begin
          finished_peers_next = finished_peers + lmn_pkg::CNT_W'(1);
        end
      end
      lmn_pkg::FN_LOCAL_FINISH: begin
        kind_next  = lmn_pkg::KIND_DONE;
        bcast_next = 1'b1;
      end
      default: begin
        // unused code: no state change, nothing sent
      end
    endcase
  end

  // Grant: enough replies and own request at the queue head
  always_comb begin
    needed = (node_count > finished_peers) ?
             (node_count - finished_peers - lmn_pkg::CNT_W'(1)) : '0;
    grant  = waiting_entry && (reply_count >= needed) && qstat.head_valid &&
             (qstat.head_stamp == own_stamp) && (qstat.head_node == own_node);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lmn_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = lmn_pkg::ST_SCAN;
        end
      end
      lmn_pkg::ST_SCAN: begin
        if (qstat.done) begin
          state_next = lmn_pkg::ST_RESULT;
        end
      end
      lmn_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = lmn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lmn_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_node   <= '0;
      node_count <= lmn_pkg::NODE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lmn_pkg::CFG_OWN_NODE:   own_node   <= cfg_data[lmn_pkg::NODE_W-1:0];
        lmn_pkg::CFG_NODE_COUNT: node_count <= cfg_data[lmn_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Node state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      logical_clock  <= '0;
      reply_count    <= '0;
      finished_peers <= '0;
      own_stamp      <= '0;
      waiting_entry  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        logical_clock  <= logical_clock_next;
        reply_count    <= reply_count_next;
        finished_peers <= finished_peers_next;
        own_stamp      <= own_stamp_next;
        waiting_entry  <= waiting_entry_next;
      end
      if ((state == lmn_pkg::ST_RESULT) && out_free) begin
        out_valid <= 1'b1;
        if (grant) begin
          waiting_entry <= 1'b0;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pending message fields and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_kind  <= kind_next;
      pend_bcast <= bcast_next;
      pend_dest  <= dest_next;
      pend_stamp <= sstamp_next;
    end
    if ((state == lmn_pkg::ST_RESULT) && out_free) begin
      out_data.send_kind      <= pend_kind;
      out_data.send_broadcast <= pend_bcast;
      out_data.send_dest      <= pend_dest;
      out_data.send_stamp     <= pend_stamp;
      out_data.enter_granted  <= grant;
      out_data.entry_clock    <= grant ? lmn_pkg::STAMP_W'(logical_clock) : '0;
    end
  end

  // Request queue and scan unit
  lmn_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .cmd  (qcmd),
    .stat (qstat)
  );

endmodule

// ===== rtl/lmn_queue.sv =====
// ----------------------------------------------------------------------------
// lmn_queue: request queue with a one-entry-per-cycle scan unit
// On start, visits every slot once: finds the key, the first free slot and
// the least (stamp, node) entry, then applies the insert or erase and
// reports the queue head as it stands after the update.
// ----------------------------------------------------------------------------
module lmn_queue (
  input  logic            clk,
  input  logic            rst,
  input  lmn_pkg::q_cmd_t cmd,
  output lmn_pkg::q_stat_t stat
);

  // Queue storage
  logic [lmn_pkg::MAX_NODES-1:0]  valid;
  logic [lmn_pkg::NODE_W-1:0]     qnode  [lmn_pkg::MAX_NODES];
  logic [lmn_pkg::CLOCK_BITS-1:0] qstamp [lmn_pkg::MAX_NODES];

  // Scan state
  logic                           busy;
  logic [lmn_pkg::IDX_W-1:0]      idx;
  lmn_pkg::q_op_t                 key_op;
  logic [lmn_pkg::CLOCK_BITS-1:0] key_stamp;
  logic [lmn_pkg::NODE_W-1:0]     key_node;
  logic                           match_found;
  logic [lmn_pkg::IDX_W-1:0]      match_idx;
  logic                           free_found;
  logic [lmn_pkg::IDX_W-1:0]      free_idx;
  logic                           best_v;
  logic [lmn_pkg::CLOCK_BITS-1:0] best_stamp;
  logic [lmn_pkg::NODE_W-1:0]     best_node;

  // Result
  logic                           done;
  logic                           head_valid;
  logic [lmn_pkg::CLOCK_BITS-1:0] head_stamp;
  logic [lmn_pkg::NODE_W-1:0]     head_node;

  // Per-entry evaluation
  logic                           hit;
  logic                           cand;
  logic                           take;
  logic                           best_v_next;
  logic [lmn_pkg::CLOCK_BITS-1:0] best_stamp_next;
  logic [lmn_pkg::NODE_W-1:0]     best_node_next;
  logic                           match_found_next;
  logic [lmn_pkg::IDX_W-1:0]      match_idx_next;
  logic                           free_found_next;
  logic [lmn_pkg::IDX_W-1:0]      free_idx_next;
  logic                           ins;
  logic                           del;
  logic                           take_key;
  logic                           last;

  always_comb begin
    hit  = valid[idx] && (qstamp[idx] == key_stamp) && (qnode[idx] == key_node);
    // an entry being erased does not compete for the head
    cand = valid[idx] && !((key_op == lmn_pkg::Q_ERASE) && hit);
    take = cand && (!best_v ||
                    lmn_pkg::key_less(qstamp[idx], qnode[idx], best_stamp, best_node));

    best_v_next     = best_v | take;
    best_stamp_next = take ? qstamp[idx] : best_stamp;
    best_node_next  = take ? qnode[idx]  : best_node;

    match_found_next = match_found | hit;
    match_idx_next   = match_found ? match_idx : idx;
    free_found_next  = free_found | !valid[idx];
    free_idx_next    = free_found ? free_idx : idx;

    // insert only when the pair is absent and a slot is free
    ins = (key_op == lmn_pkg::Q_INSERT) && !match_found_next && free_found_next;
    del = (key_op == lmn_pkg::Q_ERASE) && match_found_next;
    take_key = ins && (!best_v_next ||
                       lmn_pkg::key_less(key_stamp, key_node,
                                         best_stamp_next, best_node_next));
    last = (idx == lmn_pkg::IDX_W'(lmn_pkg::MAX_NODES - 1));
  end

  // Scan sequencer and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      valid <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy        <= 1'b1;
        idx         <= '0;
        key_op      <= cmd.op;
        key_stamp   <= cmd.stamp;
        key_node    <= cmd.node;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        best_v      <= 1'b0;
      end else if (busy) begin
        idx         <= idx + lmn_pkg::IDX_W'(1);
        match_found <= match_found_next;
        match_idx   <= match_idx_next;
        free_found  <= free_found_next;
        free_idx    <= free_idx_next;
        best_v      <= best_v_next;
        best_stamp  <= best_stamp_next;
        best_node   <= best_node_next;
        if (last) begin
          busy       <= 1'b0;
          done       <= 1'b1;
          head_valid <= best_v_next | take_key;
          head_stamp <= take_key ? key_stamp : best_stamp_next;
          head_node  <= take_key ? key_node  : best_node_next;
          if (ins) begin
            valid[free_idx_next] <= 1'b1;
          end
          if (del) begin
            valid[match_idx_next] <= 1'b0;
          end
        end
      end
    end
  end

  // Entry payload, written on insert
  always_ff @(posedge clk) begin
    if (busy && last && ins) begin
      qstamp[free_idx_next] <= key_stamp;
      qnode[free_idx_next]  <= key_node;
    end
  end

  assign stat.done       = done;
  assign stat.head_valid = head_valid;
  assign stat.head_stamp = head_stamp;
  assign stat.head_node  = head_node;

endmodule

// ===== dv/lmn_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmn_checker: result checker for the Lamport mutex node
// Watches the configuration port and both message channels, keeps its own
// model of the node (clock, request queue, counters) and compares every
// accepted result with the oldest predicted outgoing message.
// ----------------------------------------------------------------------------
module lmn_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lmn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  lmn_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  lmn_pkg::out_item_t            out_data,
  output int                            fail_count,
  output int                            result_count,
  output int                            left_count
);
  import lmn_pkg::*;

  localparam int REPORT_MAX = 10;

  // Node model
  logic [NODE_W-1:0]     my_node;
  logic [CNT_W-1:0]      nodes;
  logic [CLOCK_BITS-1:0] lam_clock;
  bit                    slot_used  [MAX_NODES];
  logic [NODE_W-1:0]     slot_node  [MAX_NODES];
  logic [CLOCK_BITS-1:0] slot_stamp [MAX_NODES];
  logic [CNT_W-1:0]      replies;
  logic [CNT_W-1:0]      peers_done;
  logic [CLOCK_BITS-1:0] my_stamp;
  bit                    want_entry;

  // Predicted outgoing messages, oldest first
  out_item_t outbox [$];
  int fails;
  int results;

  initial begin
    fails   = 0;
    results = 0;
  end

  function automatic logic [CLOCK_BITS-1:0] tick(input logic [CLOCK_BITS-1:0] v);
    return (v == {CLOCK_BITS{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic int find_slot(input logic [CLOCK_BITS-1:0] st,
                                   input logic [NODE_W-1:0] nd);
    for (int i = 0; i < MAX_NODES; i++)
      if (slot_used[i] && slot_stamp[i] == st && slot_node[i] == nd) return i;
    return -1;
  endfunction

  // Set semantics; a full queue drops the insert
  function automatic void add_req(input logic [CLOCK_BITS-1:0] st,
                                  input logic [NODE_W-1:0] nd);
    if (find_slot(st, nd) >= 0) return;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (!slot_used[i]) begin
        slot_used[i]  = 1'b1;
        slot_stamp[i] = st;
        slot_node[i]  = nd;
        return;
      end
    end
  endfunction

  function automatic void drop_req(input logic [CLOCK_BITS-1:0] st,
                                   input logic [NODE_W-1:0] nd);
    int k;
    k = find_slot(st, nd);
    if (k >= 0) slot_used[k] = 1'b0;
  endfunction

  // Own request is queued and is the least (stamp, node) entry
  function automatic bit my_request_leads();
    int best;
    best = -1;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (!slot_used[i]) continue;
      if (best < 0 || slot_stamp[i] < slot_stamp[best] ||
          (slot_stamp[i] == slot_stamp[best] && slot_node[i] < slot_node[best]))
        best = i;
    end
    return best >= 0 && slot_stamp[best] == my_stamp && slot_node[best] == my_node;
  endfunction

  // Update the model with one transaction and return the message it causes
  function automatic out_item_t next_message(input in_item_t m);
    out_item_t r;
    int needed;
    r = '0;
    case (m.func)
      FN_LOCAL_REQ: begin
        if (!want_entry) begin
          lam_clock  = tick(lam_clock);
          my_stamp   = lam_clock;
          add_req(my_stamp, my_node);
          replies    = '0;
          want_entry = 1'b1;
          r.send_kind      = KIND_REQUEST;
          r.send_broadcast = 1'b1;
          r.send_stamp     = STAMP_W'(my_stamp);
        end
      end
      FN_LOCAL_EXIT: begin
        drop_req(my_stamp, my_node);
        want_entry = 1'b0;
        r.send_kind      = KIND_RELEASE;
        r.send_broadcast = 1'b1;
        r.send_stamp     = STAMP_W'(my_stamp);
      end
      FN_GOT_REQ: begin
        lam_clock = tick((lam_clock > CLOCK_BITS'(m.stamp)) ? lam_clock
                                                            : CLOCK_BITS'(m.stamp));
        add_req(CLOCK_BITS'(m.stamp), m.sender);
        r.send_kind  = KIND_REPLY;
        r.send_dest  = m.sender;
        r.send_stamp = STAMP_W'(lam_clock);
      end
      FN_GOT_REPLY: if (replies != CNT_MAX) replies = replies + 1'b1;
      FN_GOT_RELEASE: drop_req(CLOCK_BITS'(m.stamp), m.sender);
      FN_GOT_DONE: if (peers_done != CNT_MAX) peers_done = peers_done + 1'b1;
      FN_LOCAL_FINISH: begin
        r.send_kind      = KIND_DONE;
        r.send_broadcast = 1'b1;
      end
      default: ;
    endcase

    // Grant check after every transaction
    needed = int'(nodes) - 1 - int'(peers_done);
    if (needed < 0) needed = 0;
    if (want_entry && int'(replies) >= needed && my_request_leads()) begin
      want_entry      = 1'b0;
      r.enter_granted = 1'b1;
      r.entry_clock   = STAMP_W'(lam_clock);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp;
    bit bad;
    if (rst) begin
      my_node    = '0;
      nodes      = NODE_COUNT_RST;
      lam_clock  = '0;
      replies    = '0;
      peers_done = '0;
      my_stamp   = '0;
      want_entry = 1'b0;
      for (int i = 0; i < MAX_NODES; i++) begin
        slot_used[i]  = 1'b0;
        slot_node[i]  = '0;
        slot_stamp[i] = '0;
      end
      outbox.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_NODE:   my_node = cfg_data[NODE_W-1:0];
          CFG_NODE_COUNT: nodes   = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) outbox.push_back(next_message(in_data));

      if (out_valid && out_ready) begin
        results++;
        if (outbox.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("[%0t] result %0d arrived with nothing predicted", $time, results);
        end else begin
          exp = outbox.pop_front();
          bad = (out_data.send_kind      !== exp.send_kind)      ||
                (out_data.send_broadcast !== exp.send_broadcast) ||
                (out_data.send_dest      !== exp.send_dest)      ||
                (out_data.send_stamp     !== exp.send_stamp)     ||
                (out_data.enter_granted  !== exp.enter_granted)  ||
                (out_data.entry_clock    !== exp.entry_clock);
          if (bad) begin
            fails++;
            if (fails <= REPORT_MAX) begin
              $display("[%0t] result %0d mismatch (exp/got): kind %0d/%0d bcast %0d/%0d dest %0d/%0d",
                       $time, results, exp.send_kind, out_data.send_kind,
                       exp.send_broadcast, out_data.send_broadcast,
                       exp.send_dest, out_data.send_dest);
              $display("    stamp %h/%h granted %0d/%0d entry_clock %h/%h",
                       exp.send_stamp, out_data.send_stamp,
                       exp.enter_granted, out_data.enter_granted,
                       exp.entry_clock, out_data.entry_clock);
            end
          end
        end
      end
    end
    fail_count   <= fails;
    result_count <= results;
    left_count   <= outbox.size();
  end

endmodule

// ===== dv/tb_lamport_mutex_node_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lamport_mutex_node_top: testbench for the Lamport mutex node
// Drives directed message sequences, then request/reply/release rounds mixed
// with random messages over several node settings, with random stalls on
// both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lamport_mutex_node_top;
  import lmn_pkg::*;

  localparam int LATENCY        = MAX_NODES + 3;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 100;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [STAMP_W-1:0] stamp;
  } queued_req_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  int fail_count;
  int result_count;
  int left_count;

  // Stimulus bookkeeping
  int                 n_sent       = 0;
  int                 grants_seen  = 0;
  int                 settings_run = 0;
  logic [NODE_W-1:0]  cur_own      = '0;
  logic [CNT_W-1:0]   cur_count    = NODE_COUNT_RST;
  logic [STAMP_W-1:0] stamp_base   = '0;
  bit                 idle_en      = 1'b1;
  bit                 hold_req     = 1'b0;
  queued_req_t        peer_reqs [$];   // peer requests sent, not yet released
  queued_req_t        own_reqs  [$];   // own requests seen on the output

  lamport_mutex_node_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lmn_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .result_count (result_count),
    .left_count   (left_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [STAMP_W-1:0] bump(input logic [STAMP_W-1:0] v);
    return (v == {STAMP_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  // Stamp near the node's estimated clock, so ties and both orders occur
  function automatic logic [STAMP_W-1:0] peer_stamp();
    int v;
    v = int'(stamp_base) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return STAMP_W'(v);
  endfunction

  // A participating node other than this one, where one exists
  function automatic logic [NODE_W-1:0] pick_peer();
    logic [NODE_W-1:0] s;
    if (cur_count <= 1 && cur_own == 0) return NODE_W'($urandom);
    do s = NODE_W'($urandom_range(0, int'(cur_count) - 1));
    while (s == cur_own && cur_count > 1);
    return s;
  endfunction

  // One input transaction, with an optional idle burst ahead of it
  task automatic send_msg(input logic [FUNC_W-1:0] f, input logic [NODE_W-1:0] s,
                          input logic [STAMP_W-1:0] st);
    in_item_t m;
    m.func   = f;
    m.sender = s;
    m.stamp  = st;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    if (f == FN_GOT_REQ) begin
      peer_reqs.push_back('{s, st});
      stamp_base = bump((st > stamp_base) ? st : stamp_base);
    end else if (f == FN_LOCAL_REQ) begin
      stamp_base = bump(stamp_base);
    end
  endtask

  // Sender pause until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (result_count != n_sent);
  endtask

  task automatic set_node(input logic [NODE_W-1:0] own, input logic [CNT_W-1:0] cnt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_NODE;
    cfg_data  <= CFG_DATA_W'(own);
    @(posedge clk);
    cfg_index <= CFG_NODE_COUNT;
    cfg_data  <= CFG_DATA_W'(cnt);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_own   = own;
    cur_count = cnt;
    settings_run++;
  endtask

  task automatic release_peer();
    int k;
    queued_req_t r;
    if (peer_reqs.size() == 0) return;
    k = $urandom_range(0, peer_reqs.size() - 1);
    r = peer_reqs[k];
    peer_reqs.delete(k);
    send_msg(FN_GOT_RELEASE, r.node, r.stamp);
  endtask

  // Release stale own requests, sent as if from this node
  task automatic release_own();
    queued_req_t stale [$];
    stale = own_reqs;
    own_reqs.delete();
    foreach (stale[i]) send_msg(FN_GOT_RELEASE, stale[i].node, stale[i].stamp);
  endtask

  // Well-formed round: peer requests, own request, replies, releases, exit
  task automatic run_round();
    int replies;
    if (own_reqs.size() != 0 && $urandom_range(0, 2) == 0) release_own();
    repeat ($urandom_range(0, 2)) send_msg(FN_GOT_REQ, pick_peer(), peer_stamp());
    send_msg(FN_LOCAL_REQ, NODE_W'($urandom), STAMP_W'($urandom));
    repeat ($urandom_range(0, 1)) send_msg(FN_GOT_REQ, pick_peer(), peer_stamp());
    replies = (cur_count > 0) ? int'(cur_count) - 1 : 0;
    case ($urandom_range(0, 9))
      0: if (replies > 0) replies--;
      1: replies++;
      default: ;
    endcase
    for (int i = 0; i < replies; i++) begin
      send_msg(FN_GOT_REPLY, pick_peer(), STAMP_W'($urandom));
      if ($urandom_range(0, 2) == 0) release_peer();
    end
    while (peer_reqs.size() > 0 && $urandom_range(0, 3) != 0) release_peer();
    if ($urandom_range(0, 9) != 0)
      send_msg(FN_LOCAL_EXIT, NODE_W'($urandom), STAMP_W'($urandom));
  endtask

  // Random message; done is kept rare since it lowers the reply need for good
  task automatic send_noise();
    logic [FUNC_W-1:0] f;
    if ($urandom_range(0, 99) < 2) begin
      f = FN_GOT_DONE;
    end else begin
      f = FUNC_W'($urandom_range(0, 7));
      if (f == FN_GOT_DONE) f = FN_GOT_REPLY;
    end
    if (f == FN_GOT_REQ)
      send_msg(f, NODE_W'($urandom),
               ($urandom_range(0, 9) == 0) ? STAMP_W'(0) : peer_stamp());
    else
      send_msg(f, NODE_W'($urandom), STAMP_W'($urandom));
  endtask

  // Overfill the queue, request with it full, then empty it again
  task automatic flood_queue();
    repeat (MAX_NODES + 2) send_msg(FN_GOT_REQ, NODE_W'($urandom), peer_stamp());
    send_msg(FN_LOCAL_REQ, NODE_W'($urandom), STAMP_W'($urandom));
    repeat (int'(cur_count)) send_msg(FN_GOT_REPLY, pick_peer(), STAMP_W'($urandom));
    send_msg(FN_LOCAL_EXIT, NODE_W'($urandom), STAMP_W'($urandom));
    while (peer_reqs.size() > 0) release_peer();
  endtask

  // Bring the queue back to empty between settings
  task automatic drain_and_clear();
    wait_idle();
    release_own();
    while (peer_reqs.size() > 0) release_peer();
    send_msg(FN_LOCAL_EXIT, NODE_W'($urandom), STAMP_W'($urandom));
    wait_idle();
  endtask

  // Result side: random stalls, one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Note own requests and grants as they leave the node
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (out_data.send_kind == KIND_REQUEST)
        own_reqs.push_back('{cur_own, out_data.send_stamp});
      if (out_data.enter_granted) grants_seen++;
    end
  end

  // Watchdog: too long without any transaction
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // Main stimulus
  initial begin
    logic [NODE_W-1:0] own;
    logic [CNT_W-1:0]  cnt;
    int start;
    int pick;
    bit hold_done;
    hold_done = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset settings (node 0 of 3)
    send_msg(FN_UNUSED, 4'd15, 16'hFFFF);            // unused code
    send_msg(FN_LOCAL_FINISH, 4'd0, 16'h0000);
    send_msg(FN_LOCAL_EXIT, 4'd0, 16'h0000);         // exit with no request
    send_msg(FN_GOT_RELEASE, 4'd15, 16'hFFFF);       // release of nothing queued
    send_msg(FN_GOT_REPLY, 4'd1, 16'h0000);
    send_msg(FN_GOT_DONE, 4'd2, 16'h0000);           // one reply needed now
    send_msg(FN_LOCAL_REQ, 4'd0, 16'h0000);
    send_msg(FN_LOCAL_REQ, 4'd15, 16'hFFFF);         // ignored while waiting
    send_msg(FN_GOT_REQ, 4'd0, 16'h0000);            // sender equal to own id, heads
    send_msg(FN_GOT_REPLY, 4'd1, 16'hFFFF);          // enough replies, not at head
    send_msg(FN_GOT_RELEASE, 4'd0, 16'h0000);        // now at head: grant
    send_msg(FN_GOT_REQ, 4'd15, 16'd5);
    send_msg(FN_GOT_REQ, 4'd15, 16'd5);              // duplicate entry
    send_msg(FN_LOCAL_EXIT, 4'd0, 16'h0000);
    send_msg(FN_GOT_RELEASE, 4'd15, 16'd5);
    send_msg(FN_LOCAL_REQ, 4'd0, 16'h0000);
    send_msg(FN_GOT_REPLY, 4'd2, 16'h0000);
    send_msg(FN_LOCAL_EXIT, 4'd0, 16'h0000);
    drain_and_clear();

    // Random part over several settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin own = 4'd15; cnt = 5'd16; end
        1: begin own = 4'd0;  cnt = 5'd1;  end
        2: begin own = 4'd6;  cnt = 5'd2;  end
        default: begin
          own = NODE_W'($urandom);
          cnt = CNT_W'($urandom_range(1, MAX_NODES));
        end
      endcase
      idle_en = (p != 3);
      set_node(own, cnt);
      start = n_sent;
      while (n_sent - start < PHASE_ITEMS) begin
        if (p == 0 && !hold_done && n_sent - start > PHASE_ITEMS / 2) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70)      run_round();
        else if (pick < 97) repeat ($urandom_range(1, 4)) send_noise();
        else                flood_queue();
      end
      drain_and_clear();
    end

    // Last part, no idling: saturated clock and counters
    idle_en = 1'b0;
    set_node(4'd9, 5'd4);
    send_msg(FN_GOT_REQ, 4'd2, 16'hFFFF);
    repeat (12) run_round();
    flood_queue();
    repeat (35) send_msg(FN_GOT_REPLY, NODE_W'($urandom), STAMP_W'($urandom));
    repeat (35) send_msg(FN_GOT_DONE, NODE_W'($urandom), STAMP_W'($urandom));
    repeat (8) run_round();
    drain_and_clear();

    repeat (2 * LATENCY) @(posedge clk);
    $display("Summary: %0d messages over %0d node settings, %0d entries granted",
             n_sent, settings_run, grants_seen);
    $display("Summary: included full queue, saturated clock and counters, long output stall");
    if (fail_count == 0 && left_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lmn_pkg.sv
rtl/lmn_queue.sv
rtl/lamport_mutex_node_top.sv
dv/lmn_checker.sv
dv/tb_lamport_mutex_node_top.sv
